FILE: sv/acr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the AVC configuration record converter.
// Used by acr_front, acr_queue, acr_back and avc_config_record_to_annexb.
package acr_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_EMIT   = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  localparam logic [15:0] MAX_LEN_RESET = 16'd256;

  // Field kinds.
  localparam logic [3:0] K_NONE      = 4'd0;
  localparam logic [3:0] K_VERSION   = 4'd1;
  localparam logic [3:0] K_PROFILE   = 4'd2;
  localparam logic [3:0] K_COMPAT    = 4'd3;
  localparam logic [3:0] K_LEVEL     = 4'd4;
  localparam logic [3:0] K_LENSIZE   = 4'd5;
  localparam logic [3:0] K_SPS_COUNT = 4'd6;
  localparam logic [3:0] K_SET_LEN   = 4'd7;
  localparam logic [3:0] K_PPS_COUNT = 4'd8;

  // Status codes.
  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_VERSION  = 4'd1;
  localparam logic [3:0] ST_PROFILE  = 4'd2;
  localparam logic [3:0] ST_RES6     = 4'd3;
  localparam logic [3:0] ST_RES3     = 4'd4;
  localparam logic [3:0] ST_TOO_LONG = 4'd5;
  localparam logic [3:0] ST_NAL_TYPE = 4'd6;
  localparam logic [3:0] ST_TRUNC    = 4'd7;
  localparam logic [3:0] ST_DONE     = 4'd8;

  localparam logic [4:0] NAL_SPS = 5'd7;
  localparam logic [4:0] NAL_PPS = 5'd8;

  typedef enum logic [3:0] {
    PH_IDLE, PH_PROFILE, PH_COMPAT, PH_LEVEL, PH_LENSIZE, PH_SPSCOUNT,
    PH_LEN_HI, PH_LEN_LO, PH_FIRST, PH_PAYLOAD, PH_PPSCOUNT, PH_DONE, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    BK_START, BK_SC1, BK_SC2, BK_SC3, BK_REPORT
  } step_t;

  // One parsed byte: an optional truncation request, an optional start code
  // and the report request that closes the run.
  typedef struct packed {
    logic        has_trunc;
    logic [15:0] trunc_err;
    logic        has_sc;
    logic [7:0]  stream_byte;
    logic        stream_valid;
    logic [3:0]  kind;
    logic [15:0] value;
    logic [3:0]  status;
    logic [15:0] err;
  } cmd_t;

endpackage

FILE: sv/acr_front.sv
`timescale 1ns / 1ps
// Front end: parses record bytes and turns each byte of a record, up to its end or a fatal error, into a command.
// Depends on acr_pkg.
module acr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_record_start,
  input  logic          cfg_emit,
  input  logic [15:0]   cfg_max_len,
  input  logic          q_full,
  output logic          push,
  output acr_pkg::cmd_t cmd
);
  import acr_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  sets_r, sets_nxt;
  logic        in_pps_r, in_pps_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] pay_r, pay_nxt;
  logic [15:0] err_r, err_nxt;
  logic        emit_set_r, emit_set_nxt;

  logic        accept;
  logic        active;
  logic        trunc;
  logic        bad;
  logic        produce;
  logic [15:0] err_a;
  logic [15:0] len_word;
  logic        too_long;
  logic        type_ok;
  logic [15:0] pay_dec;
  logic        last_byte;
  logic [7:0]  sets_dec;
  phase_t      fin_phase;
  logic [3:0]  fin_status;

  function automatic logic [15:0] sat_inc(input logic [15:0] v, input logic inc);
    return (inc && v != 16'hFFFF) ? v + 16'd1 : v;
  endfunction

  function automatic logic known_profile(input logic [7:0] p);
    return p == 8'd66 || p == 8'd77 || p == 8'd100 || p == 8'd110 ||
           p == 8'd122 || p == 8'd244;
  endfunction

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign active    = phase_r != PH_IDLE && phase_r != PH_DONE && phase_r != PH_HALT;
  assign len_word  = {len_hi_r, in_byte};
  assign too_long  = len_word > cfg_max_len;
  assign type_ok   = in_byte[4:0] == (in_pps_r ? NAL_PPS : NAL_SPS);
  assign pay_dec   = pay_r - 16'd1;
  assign last_byte = pay_dec == 16'd0;
  assign sets_dec  = sets_r - 8'd1;
  assign fin_phase  = (sets_dec != 8'd0) ? PH_LEN_HI : (in_pps_r ? PH_DONE : PH_PPSCOUNT);
  assign fin_status = (sets_dec == 8'd0 && in_pps_r) ? ST_DONE : ST_OK;

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (in_record_start) begin
        phase_nxt = PH_PROFILE;
      end else begin
        unique case (phase_r)
          PH_PROFILE:  phase_nxt = PH_COMPAT;
          PH_COMPAT:   phase_nxt = PH_LEVEL;
          PH_LEVEL:    phase_nxt = PH_LENSIZE;
          PH_LENSIZE:  phase_nxt = PH_SPSCOUNT;
          PH_SPSCOUNT: phase_nxt = (in_byte[4:0] != 5'd0) ? PH_LEN_HI : PH_PPSCOUNT;
          PH_PPSCOUNT: phase_nxt = (in_byte == 8'd0) ? PH_DONE : PH_LEN_HI;
          PH_LEN_HI:   phase_nxt = PH_LEN_LO;
          PH_LEN_LO:   phase_nxt = (too_long || len_word == 16'd0) ? PH_HALT : PH_FIRST;
          PH_FIRST:    phase_nxt = !type_ok ? PH_HALT : (last_byte ? fin_phase : PH_PAYLOAD);
          PH_PAYLOAD:  phase_nxt = last_byte ? fin_phase : PH_PAYLOAD;
          default:     phase_nxt = phase_r;
        endcase
      end
    end
  end

  always_comb begin
    sets_nxt     = sets_r;
    in_pps_nxt   = in_pps_r;
    len_hi_nxt   = len_hi_r;
    pay_nxt      = pay_r;
    emit_set_nxt = emit_set_r;
    cmd          = '0;
    bad          = 1'b0;
    produce      = 1'b0;
    trunc        = in_record_start && active;
    err_a        = sat_inc(err_r, trunc);
    cmd.has_trunc = trunc;
    cmd.trunc_err = err_a;
    if (in_record_start) begin
      produce      = 1'b1;
      sets_nxt     = '0;
      in_pps_nxt   = 1'b0;
      len_hi_nxt   = '0;
      pay_nxt      = '0;
      emit_set_nxt = 1'b0;
      bad          = in_byte != 8'd1;
      cmd.kind     = K_VERSION;
      cmd.value    = {8'd0, in_byte};
      cmd.status   = bad ? ST_VERSION : ST_OK;
    end else begin
      unique case (phase_r)
        PH_PROFILE: begin
          produce    = 1'b1;
          bad        = !known_profile(in_byte);
          cmd.kind   = K_PROFILE;
          cmd.value  = {8'd0, in_byte};
          cmd.status = bad ? ST_PROFILE : ST_OK;
        end
        PH_COMPAT: begin
          produce   = 1'b1;
          cmd.kind  = K_COMPAT;
          cmd.value = {8'd0, in_byte};
        end
        PH_LEVEL: begin
          produce   = 1'b1;
          cmd.kind  = K_LEVEL;
          cmd.value = {8'd0, in_byte};
        end
        PH_LENSIZE: begin
          produce    = 1'b1;
          bad        = in_byte[7:2] != 6'h3F;
          cmd.kind   = K_LENSIZE;
          cmd.value  = {14'd0, in_byte[1:0]} + 16'd1;
          cmd.status = bad ? ST_RES6 : ST_OK;
        end
        PH_SPSCOUNT: begin
          produce    = 1'b1;
          bad        = in_byte[7:5] != 3'h7;
          sets_nxt   = {3'd0, in_byte[4:0]};
          in_pps_nxt = 1'b0;
          cmd.kind   = K_SPS_COUNT;
          cmd.value  = {11'd0, in_byte[4:0]};
          cmd.status = bad ? ST_RES3 : ST_OK;
        end
        PH_PPSCOUNT: begin
          produce    = 1'b1;
          sets_nxt   = in_byte;
          in_pps_nxt = 1'b1;
          cmd.kind   = K_PPS_COUNT;
          cmd.value  = {8'd0, in_byte};
          cmd.status = (in_byte == 8'd0) ? ST_DONE : ST_OK;
        end
        PH_LEN_HI: begin
          produce    = 1'b1;
          len_hi_nxt = in_byte;
        end
        PH_LEN_LO: begin
          produce   = 1'b1;
          cmd.kind  = K_SET_LEN;
          cmd.value = len_word;
          if (too_long) begin
            bad        = 1'b1;
            cmd.status = ST_TOO_LONG;
          end else if (len_word == 16'd0) begin
            // An empty set has no NAL header, so it counts as the wrong type.
            bad        = 1'b1;
            cmd.status = ST_NAL_TYPE;
          end else begin
            pay_nxt = len_word;
          end
        end
        PH_FIRST: begin
          produce = 1'b1;
          if (!type_ok) begin
            bad        = 1'b1;
            cmd.status = ST_NAL_TYPE;
          end else begin
            emit_set_nxt     = cfg_emit;
            cmd.has_sc       = cfg_emit;
            cmd.stream_byte  = cfg_emit ? in_byte : 8'd0;
            cmd.stream_valid = cfg_emit;
            pay_nxt          = pay_dec;
            if (last_byte) begin
              sets_nxt   = sets_dec;
              cmd.status = fin_status;
            end
          end
        end
        PH_PAYLOAD: begin
          produce          = 1'b1;
          cmd.stream_byte  = emit_set_r ? in_byte : 8'd0;
          cmd.stream_valid = emit_set_r;
          pay_nxt          = pay_dec;
          if (last_byte) begin
            sets_nxt   = sets_dec;
            cmd.status = fin_status;
          end
        end
        default: produce = 1'b0;
      endcase
    end
    err_nxt = sat_inc(err_a, bad);
    cmd.err = err_nxt;
    push    = accept && produce;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      sets_r     <= '0;
      in_pps_r   <= 1'b0;
      len_hi_r   <= '0;
      pay_r      <= '0;
      err_r      <= '0;
      emit_set_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      sets_r     <= sets_nxt;
      in_pps_r   <= in_pps_nxt;
      len_hi_r   <= len_hi_nxt;
      pay_r      <= pay_nxt;
      err_r      <= err_nxt;
      emit_set_r <= emit_set_nxt;
    end
  end

`ifndef SYNTHESIS
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_record_start && (phase_r == PH_HALT || phase_r == PH_IDLE ||
     phase_r == PH_DONE)) |-> !push)
    else $error("front pushed a command for an ignored byte");
  a_trunc_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cmd.has_trunc) |-> (in_record_start && !cmd.has_sc))
    else $error("truncation request without a record start");
  a_err_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 err_r >= $past(err_r))
    else $error("error counter went backwards");
`endif

endmodule

FILE: sv/acr_queue.sv
`timescale 1ns / 1ps
// Short command queue between the parser front end and the result sequencer.
// Depends on acr_pkg.
module acr_queue #(
  parameter int DEPTH = acr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  acr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output acr_pkg::cmd_t head
);
  import acr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == CNT_W'(DEPTH);
  assign q_valid = count_r != '0;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from an empty queue");
`endif

endmodule

FILE: sv/acr_back.sv
`timescale 1ns / 1ps
// Back end: expands each queued command into its results and drives the
// registered output channel. Depends on acr_pkg.
module acr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  acr_pkg::cmd_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_stream_byte,
  output logic          out_stream_valid,
  output logic [3:0]    out_field_kind,
  output logic [15:0]   out_field_value,
  output logic [3:0]    out_status,
  output logic [15:0]   out_error_total,
  output logic          out_last_of_run
);
  import acr_pkg::*;

  step_t       step_r, step_nxt;
  logic        out_valid_r;
  logic [7:0]  byte_r;
  logic        sval_r;
  logic [3:0]  kind_r;
  logic [15:0] value_r;
  logic [3:0]  status_r;
  logic [15:0] err_r;
  logic        last_r;

  logic        load;
  logic        report_sel;
  logic [7:0]  res_byte;
  logic        res_sval;
  logic [3:0]  res_kind;
  logic [15:0] res_value;
  logic [3:0]  res_status;
  logic [15:0] res_err;
  logic        res_last;

  assign load       = q_valid && (!out_valid_r || out_ready);
  assign report_sel = (step_r == BK_REPORT) ||
                      (step_r == BK_START && !head.has_trunc && !head.has_sc);

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      unique case (step_r)
        BK_START: begin
          if (head.has_trunc) begin
            step_nxt = BK_REPORT;
          end else if (head.has_sc) begin
            step_nxt = BK_SC1;
          end else begin
            step_nxt = BK_START;
          end
        end
        BK_SC1:    step_nxt = BK_SC2;
        BK_SC2:    step_nxt = BK_SC3;
        BK_SC3:    step_nxt = BK_REPORT;
        BK_REPORT: step_nxt = BK_START;
        default:   step_nxt = BK_START;
      endcase
    end
  end

  always_comb begin
    res_byte   = '0;
    res_sval   = 1'b0;
    res_kind   = K_NONE;
    res_value  = '0;
    res_status = ST_OK;
    res_err    = head.err;
    res_last   = 1'b0;
    pop        = load && report_sel;
    if (report_sel) begin
      res_byte   = head.stream_byte;
      res_sval   = head.stream_valid;
      res_kind   = head.kind;
      res_value  = head.value;
      res_status = head.status;
      res_last   = 1'b1;
    end else if (step_r == BK_START && head.has_trunc) begin
      res_status = ST_TRUNC;
      res_err    = head.trunc_err;
    end else begin
      // Start code 00 00 00 01: only its final byte is nonzero.
      res_sval = 1'b1;
      res_byte = (step_r == BK_SC3) ? 8'd1 : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= BK_START;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= res_byte;
      sval_r   <= res_sval;
      kind_r   <= res_kind;
      value_r  <= res_value;
      status_r <= res_status;
      err_r    <= res_err;
      last_r   <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_stream_byte  = byte_r;
  assign out_stream_valid = sval_r;
  assign out_field_kind   = kind_r;
  assign out_field_value  = value_r;
  assign out_status       = status_r;
  assign out_error_total  = err_r;
  assign out_last_of_run  = last_r;

`ifndef SYNTHESIS
  a_mid_run_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != BK_START) |-> q_valid)
    else $error("sequencer mid-run without a queued command");
  a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (load && res_last))
    else $error("command popped without its report request");
  a_sc_then_report: assert property (@(posedge clk) disable iff (!rst_n)
    (load && step_r == BK_SC3) |=> step_r == BK_REPORT)
    else $error("start code not followed by the report");
`endif

endmodule

FILE: sv/avc_config_record_to_annexb.sv
`timescale 1ns / 1ps
// AVC decoder configuration record parser and Annex B parameter set converter.
// Depends on acr_pkg, acr_front, acr_queue and acr_back.
//
// Record bytes enter at one per cycle; in_ready drops only when the command
// queue (Q_DEPTH entries) is full. Each parsed byte yields one report request
// (last_of_run set); a record start in the middle of a record adds a
// truncation request before it, and the first byte of an emitted parameter set
// adds four start code bytes 00 00 00 01 before it. The output register sends
// one request per cycle while out_ready is high; a byte yields 1, 2 or 5
// requests, and the queue absorbs those bursts. Bytes outside a record, after
// the end of a record or after a fatal error give no requests.
// Registers: 0x0 emit_stream (bit 0), 0x4 max_set_length (bits 15:0, reset 256);
// write them only while the block is idle.
module avc_config_record_to_annexb #(
  parameter int Q_DEPTH = acr_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_record_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_stream_byte,
  output logic                       out_stream_valid,
  output logic [3:0]                 out_field_kind,
  output logic [15:0]                out_field_value,
  output logic [3:0]                 out_status,
  output logic [15:0]                out_error_total,
  output logic                       out_last_of_run,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [acr_pkg::ADDR_W-1:0] paddr,
  input  logic [acr_pkg::DATA_W-1:0] pwdata,
  output logic [acr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import acr_pkg::*;

  logic        emit_r;
  logic [15:0] max_len_r;
  logic        cfg_wr;
  logic        reg_idx;

  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  cmd_t        head;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_r    <= 1'b0;
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_EMIT:   emit_r    <= pwdata[0];
        REG_MAXLEN: max_len_r <= pwdata[15:0];
        default:    emit_r    <= emit_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EMIT:   prdata = {{(DATA_W - 1){1'b0}}, emit_r};
      REG_MAXLEN: prdata = {{(DATA_W - 16){1'b0}}, max_len_r};
      default:    prdata = '0;
    endcase
  end

  acr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_record_start (in_record_start),
    .cfg_emit        (emit_r),
    .cfg_max_len     (max_len_r),
    .q_full          (q_full),
    .push            (push),
    .cmd             (push_cmd)
  );

  acr_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  acr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_stream_byte  (out_stream_byte),
    .out_stream_valid (out_stream_valid),
    .out_field_kind   (out_field_kind),
    .out_field_value  (out_field_value),
    .out_status       (out_status),
    .out_error_total  (out_error_total),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
